>>> hdl/crrs_pkg.sv
`default_nettype none
package crrs_pkg;
  localparam int TASK_ID_BITS = 16;

  localparam logic [1:0] FUNC_SWITCH = 2'd0;
  localparam logic [1:0] FUNC_CREATE = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [63:0]             container_id;
    logic [TASK_ID_BITS-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic                    wake_valid;
    logic [TASK_ID_BITS-1:0] wake_task;
    logic                    caller_sleeps;
    logic [1:0]              status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture request, start key or task scan
    logic key_step;  // compare one container key
    logic scan_init; // start task scan of current container
    logic scan_step; // read next queue entry
    logic cont_next; // advance to next container (switch)
    logic shift_rd;  // read entry p+1 during compaction
    logic shift_wr;  // write entry p, advance p
    logic commit;    // apply the decided update
    logic wake_rd;   // read head after update
    logic finish;    // latch result
  } cmd_t;

  typedef struct packed {
    logic key_done;
    logic key_hit;
    logic scan_done;
    logic scan_hit;
    logic cont_done;
    logic shift_done;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/crrs_if.sv
`default_nettype none
interface crrs_req_if;
  import crrs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crrs_rsp_if;
  import crrs_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/crrs_ram.sv
`default_nettype none
module crrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/crrs_datapath.sv
`default_nettype none
module crrs_datapath import crrs_pkg::*; #(
  parameter int NUM_CONTAINERS = 8,
  parameter int TASKS_PER_CONTAINER = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output rsp_t      rsp
);
  localparam int CW = (NUM_CONTAINERS > 1) ? $clog2(NUM_CONTAINERS) : 1;
  localparam int PW = $clog2(TASKS_PER_CONTAINER);
  localparam int NW = $clog2(TASKS_PER_CONTAINER + 1);
  localparam int SW = $clog2(NUM_CONTAINERS * TASKS_PER_CONTAINER);
  localparam int CCW = $clog2(NUM_CONTAINERS + 1);

  logic [NUM_CONTAINERS-1:0] cvalid;
  logic [63:0]   ckey  [NUM_CONTAINERS];
  logic [NW-1:0] ccount[NUM_CONTAINERS];
  logic [PW-1:0] chead [NUM_CONTAINERS];

  logic [1:0]              func;
  logic [63:0]             key;
  logic [TASK_ID_BITS-1:0] tid;
  logic [CCW-1:0]          c;     // container under work
  logic [NW-1:0]           p;     // position in queue
  logic                    rd_pend;
  rsp_t                    res;

  logic                    we;
  logic [SW-1:0]           waddr, raddr;
  logic [TASK_ID_BITS-1:0] wdata, rdata;

  logic [CW-1:0] ci;
  logic          c_in;
  logic [NW-1:0] cnt;
  logic [PW-1:0] hd;
  logic [CW-1:0] free_c;
  logic          free_ok;

  assign ci   = c[CW-1:0];
  assign c_in = (c < CCW'(NUM_CONTAINERS));
  assign cnt  = c_in ? ccount[ci] : '0;
  assign hd   = chead[ci];

  // Head plus position is below twice the queue size, so one subtract wraps it.
  function automatic logic [SW-1:0] slot(input logic [CW-1:0] cc, input logic [PW-1:0] h,
                                         input logic [NW-1:0] pos);
    logic [NW:0] s;
    s = {1'b0, NW'(h)} + {1'b0, pos};
    if (s >= (NW+1)'(TASKS_PER_CONTAINER)) begin
      s = s - (NW+1)'(TASKS_PER_CONTAINER);
    end
    return SW'(cc) * SW'(TASKS_PER_CONTAINER) + SW'(s);
  endfunction

  function automatic logic [PW-1:0] next_head(input logic [PW-1:0] h);
    return (h == PW'(TASKS_PER_CONTAINER - 1)) ? '0 : h + PW'(1);
  endfunction

  always_comb begin
    free_ok = 1'b0;
    free_c  = '0;
    for (int i = NUM_CONTAINERS - 1; i >= 0; i--) begin
      if (!cvalid[i]) begin
        free_ok = 1'b1;
        free_c  = CW'(i);
      end
    end
  end

  crrs_ram #(.WIDTH(TASK_ID_BITS), .DEPTH(NUM_CONTAINERS * TASKS_PER_CONTAINER)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    raddr = slot(ci, hd, p);
    if (cmd.shift_rd) begin
      raddr = slot(ci, hd, p + NW'(1));
    end else if (cmd.wake_rd) begin
      raddr = slot(ci, hd, '0);
    end
  end

  // Status toward the controller. A hit at the head needs no compaction.
  always_comb begin
    sts.key_done   = !c_in || (cvalid[ci] && ckey[ci] == key);
    sts.key_hit    = c_in && cvalid[ci] && ckey[ci] == key;
    sts.scan_done  = (rd_pend && rdata == tid) || (!rd_pend && p >= cnt);
    sts.scan_hit   = rd_pend && rdata == tid;
    sts.cont_done  = !c_in;
    sts.shift_done = (p == '0) || (p + NW'(1) >= cnt);
  end

  // Compaction writes and the commit decision, made combinationally from func and state.
  always_comb begin
    we    = 1'b0;
    waddr = slot(ci, hd, p);
    wdata = tid;
    if (cmd.shift_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.commit) begin
      case (func)
        FUNC_CREATE: begin
          if (c_in) begin
            we    = (cnt < NW'(TASKS_PER_CONTAINER));
            waddr = slot(ci, hd, cnt);
          end else begin
            we    = free_ok;
            waddr = SW'(free_c) * SW'(TASKS_PER_CONTAINER);
          end
        end
        FUNC_SWITCH: begin
          // rdata still holds the head read at scan position 0 when p==0.
          we    = c_in && cnt > NW'(1) && p == '0;
          waddr = slot(ci, hd, cnt);
          wdata = tid;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
      for (int i = 0; i < NUM_CONTAINERS; i++) begin
        ccount[i] <= '0;
        chead[i]  <= '0;
      end
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      if (cmd.load) begin
        func <= req.func;
        key  <= req.container_id;
        tid  <= req.task_id;
        c    <= '0;
        p    <= '0;
        res  <= '0;
      end
      if (cmd.key_step && !sts.key_done) begin
        c <= c + CCW'(1);
      end
      if (cmd.scan_init) begin
        p <= '0;
      end
      if (cmd.scan_step) begin
        if (rd_pend) begin
          if (rdata != tid) begin
            p <= p + NW'(1);
          end
        end else if (p < cnt) begin
          rd_pend <= 1'b1;
        end
      end
      if (cmd.cont_next) begin
        c <= c + CCW'(1);
      end
      if (cmd.shift_wr) begin
        p <= p + NW'(1);
      end
      if (cmd.commit) begin
        case (func)
          FUNC_CREATE: begin
            if (c_in) begin
              if (cnt < NW'(TASKS_PER_CONTAINER)) begin
                ccount[ci] <= cnt + NW'(1);
                res.caller_sleeps <= (cnt != '0);
              end else begin
                res.status <= ST_FULL;
              end
            end else if (free_ok) begin
              cvalid[free_c] <= 1'b1;
              ckey[free_c]   <= key;
              ccount[free_c] <= NW'(1);
              chead[free_c]  <= '0;
            end else begin
              res.status <= ST_FULL;
            end
          end
          FUNC_DELETE: begin
            if (!c_in || cnt == '0) begin
              res.status <= ST_NOTFOUND;
            end else if (cnt == NW'(1)) begin
              cvalid[ci] <= 1'b0;
              ccount[ci] <= '0;
              chead[ci]  <= '0;
            end else if (p >= cnt) begin
              res.status <= ST_NOTFOUND;
            end else begin
              if (p == '0) begin
                chead[ci] <= next_head(hd);
              end
              ccount[ci] <= cnt - NW'(1);
              res.wake_valid <= 1'b1;
            end
          end
          FUNC_SWITCH: begin
            if (!c_in) begin
              res.status <= ST_NOTFOUND;
            end else if (cnt > NW'(1)) begin
              if (p == '0) begin
                chead[ci] <= next_head(hd);
              end
              res.wake_valid    <= 1'b1;
              res.caller_sleeps <= 1'b1;
            end
          end
          default: res <= '0;
        endcase
      end
      if (cmd.finish && res.wake_valid) begin
        res.wake_task <= rdata;
      end
    end
  end

  assign rsp = res;
endmodule
`default_nettype wire

>>> hdl/crrs_ctrl.sv
`default_nettype none
module crrs_ctrl import crrs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_KEY    = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_CNEXT  = 4'd3;
  localparam logic [3:0] S_SHRD   = 4'd4;
  localparam logic [3:0] S_SHWR   = 4'd5;
  localparam logic [3:0] S_COMMIT = 4'd6;
  localparam logic [3:0] S_WAKE   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] func;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (in_func == FUNC_SWITCH) ? S_SCAN : S_KEY;
        end
      end
      S_KEY: begin
        cmd.key_step = 1'b1;
        if (sts.key_done) begin
          cmd.scan_init = 1'b1;
          state_next = (func == FUNC_DELETE && sts.key_hit) ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        if (sts.cont_done) begin
          state_next = S_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_done) begin
            if (!sts.scan_hit && func == FUNC_SWITCH) begin
              state_next = S_CNEXT;
            end else if (sts.scan_hit && func == FUNC_DELETE) begin
              state_next = S_SHRD;
            end else begin
              state_next = S_COMMIT;
            end
          end
        end
      end
      S_CNEXT: begin
        cmd.cont_next = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = S_SCAN;
      end
      S_SHRD: begin
        // Compaction only for a hit past the head.
        cmd.shift_rd = 1'b1;
        state_next = sts.shift_done ? S_COMMIT : S_SHWR;
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHRD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_WAKE;
      end
      S_WAKE: begin
        cmd.wake_rd = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      func  <= FUNC_SWITCH;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        func <= in_func;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/container_round_robin_scheduler_unit.sv
// Channel   Direction  Payload
// req       sink       func, container_id, task_id
// rsp       source     wake_valid, wake_task, caller_sleeps, status
//
// One transaction at a time. A request passes through accept, commit, head read, result
// latch and response, plus the container keys compared, the queue entries scanned,
// the containers a switch passes over, and the entries moved when a delete closes a
// gap behind the head.
// Reset clears the container table at once; no clearing pass.
// A stalled response holds the unit; no new request is taken until it leaves.
`default_nettype none
module container_round_robin_scheduler_unit import crrs_pkg::*; #(
  parameter int NUM_CONTAINERS = 8,
  parameter int TASKS_PER_CONTAINER = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  crrs_req_if.sink   req,
  crrs_rsp_if.source rsp
);
  cmd_t cmd;
  sts_t sts;

  crrs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .in_func(req.data.func), .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  crrs_datapath #(
    .NUM_CONTAINERS(NUM_CONTAINERS), .TASKS_PER_CONTAINER(TASKS_PER_CONTAINER)
  ) u_dp (
    .clk(clk), .rst(rst), .req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp.data)
  );
endmodule
`default_nettype wire
